[rtl/kfade_pkg.sv]
// shared constants, opcodes, state type and controller/datapath interface structs
package kfade_pkg;

    // field and arithmetic widths
    localparam int TIME_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int COLOR_BITS  = 8;
    localparam int CHANNELS    = 3;
    localparam int CHAN_BITS   = 2;
    localparam int QUO_BITS    = COLOR_BITS + FRAC_BITS;
    localparam int SPEED_BITS  = QUO_BITS + 1;
    localparam int CNT_BITS    = $clog2(QUO_BITS);
    localparam int PROD_BITS   = QUO_BITS + TIME_BITS;
    localparam int SAT_SHIFT   = FRAC_BITS + 10;
    localparam int TOTAL_BITS  = SAT_SHIFT + 2;
    localparam int S_DATA_BITS = 88;
    localparam int M_DATA_BITS = 32;

    localparam logic [COLOR_BITS-1:0] THRESH_RESET = 8'd16;
    localparam logic [CHAN_BITS-1:0]  CHAN_LAST    = CHAN_BITS'(CHANNELS - 1);
    localparam logic [CNT_BITS-1:0]   DIV_LAST     = CNT_BITS'(QUO_BITS - 1);

    // products above 1024 color units saturate by sign
    localparam logic [PROD_BITS-1:0]  SAT_LIMIT    = PROD_BITS'(1) << SAT_SHIFT;

    // opcodes carried in s_tuser
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;

    typedef logic [COLOR_BITS-1:0] color_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_STORE,
        ST_TICK,
        ST_MUL,
        ST_ACC,
        ST_TICK_END,
        ST_COMMIT,
        ST_RESULT
    } kfade_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic load;
        logic div_init;
        logic div_step;
        logic div_store;
        logic tick_reach;
        logic tick_start;
        logic mul;
        logic acc;
        logic tick_end;
        logic commit;
        logic result;
    } kfade_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       reached;
        logic       now_ge_target;
        logic       div_last;
        logic       chan_last;
        logic       out_free;
    } kfade_stat_t;

endpackage

[rtl/keyframe_rgb_fade_engine_unit.sv]
// top level of the keyframe rgb fade engine: controller and datapath
// a keyframe load sets the speeds with one shared restoring divider, three channels in turn
// a tick uses one 24x32 multiplier, channel by channel, and skips it at or past target
// a waiting result holds off the input until it is taken
// aresetn is synchronous, active low: all fade state zero, threshold 16, no result pending
module keyframe_rgb_fade_engine_unit import kfade_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // elapsed_ms[31:0], key_time_ms[63:32], key_red[71:64], key_green[79:72], key_blue[87:80]
    input  logic [S_DATA_BITS-1:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]             s_tuser,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // needs_update[0], past_target[1], out_red[9:2], out_green[17:10], out_blue[25:18]
    output logic [M_DATA_BITS-1:0] m_tdata,
    // threshold write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [COLOR_BITS-1:0]  cfg_data
);

    kfade_cmd_t  cmd;
    kfade_stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencer
    kfade_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and state
    kfade_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/kfade_ctrl.sv]
// sequencing state machine for load, tick and commit words
module kfade_ctrl import kfade_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  kfade_stat_t stat,
    output kfade_cmd_t  cmd
);

    kfade_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                priority case (stat.op)
                    OP_LOAD:   state_next = ST_LOAD;
                    OP_TICK:   state_next = ST_TICK;
                    OP_COMMIT: state_next = ST_COMMIT;
                    default:   state_next = ST_RESULT;
                endcase
            end
            ST_LOAD:      state_next = ST_DIV_INIT;
            ST_DIV_INIT:  state_next = ST_DIV;
            ST_DIV: begin
                if (stat.div_last) state_next = ST_DIV_STORE;
            end
            ST_DIV_STORE: begin
                state_next = stat.chan_last ? ST_RESULT : ST_DIV_INIT;
            end
            ST_TICK: begin
                if (stat.reached || stat.now_ge_target) state_next = ST_RESULT;
                else state_next = ST_MUL;
            end
            ST_MUL:       state_next = ST_ACC;
            ST_ACC: begin
                state_next = stat.chan_last ? ST_TICK_END : ST_MUL;
            end
            ST_TICK_END:  state_next = ST_RESULT;
            ST_COMMIT:    state_next = ST_RESULT;
            ST_RESULT: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_LOAD:      cmd.load      = 1'b1;
            ST_DIV_INIT:  cmd.div_init  = 1'b1;
            ST_DIV:       cmd.div_step  = 1'b1;
            ST_DIV_STORE: cmd.div_store = 1'b1;
            ST_TICK: begin
                if (!stat.reached) begin
                    cmd.tick_reach = stat.now_ge_target;
                    cmd.tick_start = !stat.now_ge_target;
                end
            end
            ST_MUL:       cmd.mul      = 1'b1;
            ST_ACC:       cmd.acc      = 1'b1;
            ST_TICK_END:  cmd.tick_end = 1'b1;
            ST_COMMIT:    cmd.commit   = 1'b1;
            ST_RESULT:    cmd.result   = stat.out_free;
            default:      cmd          = '0;
        endcase
    end

endmodule

[rtl/kfade_dp.sv]
// fade datapath: keyframe state, serial divider, multiplier, saturation, output register
module kfade_dp import kfade_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  kfade_cmd_t             cmd,
    output kfade_stat_t            stat,
    input  logic [S_DATA_BITS-1:0] s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   cfg_valid,
    input  logic [COLOR_BITS-1:0]  cfg_data,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [M_DATA_BITS-1:0] m_tdata
);

    // captured input word
    logic [1:0]           op_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] key_time_reg;
    color_t               key_color_reg [CHANNELS];

    // fade state
    logic [COLOR_BITS-1:0]        thresh_reg;
    logic [TIME_BITS-1:0]         prev_time_reg, target_time_reg;
    color_t                       prev_color_reg   [CHANNELS];
    color_t                       target_color_reg [CHANNELS];
    color_t                       shown_reg        [CHANNELS];
    color_t                       expected_reg     [CHANNELS];
    logic signed [SPEED_BITS-1:0] speed_reg        [CHANNELS];
    logic                         reached_reg, refresh_reg;

    // working registers
    logic [CHAN_BITS-1:0] chan_reg;
    logic [TIME_BITS-1:0] left_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [QUO_BITS-1:0]  quo_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 div_neg_reg;
    logic                 dneg_reg;
    logic [TIME_BITS-1:0] dmag_reg;
    logic [PROD_BITS-1:0] prod_reg;
    logic                 any_reg;

    // output register
    logic                   m_tvalid_reg;
    logic [M_DATA_BITS-1:0] m_tdata_reg;

    // divider step
    logic [TIME_BITS:0] rem_shift;
    logic               div_ge;
    logic [TIME_BITS:0] rem_sub;

    // division setup
    logic [COLOR_BITS:0] color_diff;
    logic [COLOR_BITS:0] color_mag;

    // multiplier operand
    logic [SPEED_BITS-1:0] speed_mag;

    // accumulate and saturate
    logic                         neg_dir;
    logic                         over;
    logic signed [TOTAL_BITS-1:0] base_ext, prod_ext, total;
    color_t                       sat_val;
    logic [COLOR_BITS:0]          shown_diff;
    logic [COLOR_BITS:0]          shown_abs;
    logic                         chan_any;

    // divider step logic
    always_comb begin
        rem_shift = {rem_reg, quo_reg[QUO_BITS-1]};
        rem_sub   = rem_shift - {1'b0, left_reg};
        div_ge    = rem_shift >= {1'b0, left_reg};
    end

    // color difference magnitude for the speed division
    always_comb begin
        color_diff = {1'b0, target_color_reg[chan_reg]} - {1'b0, prev_color_reg[chan_reg]};
        color_mag  = color_diff[COLOR_BITS] ? -color_diff : color_diff;
    end

    // speed magnitude
    always_comb begin
        speed_mag = speed_reg[chan_reg][SPEED_BITS-1] ? -speed_reg[chan_reg] : speed_reg[chan_reg];
    end

    // extrapolated channel value with saturation and threshold check
    always_comb begin
        neg_dir  = speed_reg[chan_reg][SPEED_BITS-1] ^ dneg_reg;
        over     = prod_reg > SAT_LIMIT;
        base_ext = $signed({{(TOTAL_BITS - COLOR_BITS - FRAC_BITS){1'b0}},
                            prev_color_reg[chan_reg], {FRAC_BITS{1'b0}}});
        prod_ext = $signed({1'b0, prod_reg[SAT_SHIFT:0]});
        total    = neg_dir ? (base_ext - prod_ext) : (base_ext + prod_ext);
        priority if (over) begin
            sat_val = neg_dir ? '0 : '1;
        end else if (total[TOTAL_BITS-1]) begin
            sat_val = '0;
        end else if (|total[TOTAL_BITS-2:COLOR_BITS+FRAC_BITS]) begin
            sat_val = '1;
        end else begin
            sat_val = total[COLOR_BITS+FRAC_BITS-1:FRAC_BITS];
        end
        shown_diff = {1'b0, sat_val} - {1'b0, shown_reg[chan_reg]};
        shown_abs  = shown_diff[COLOR_BITS] ? -shown_diff : shown_diff;
        chan_any   = shown_abs > {1'b0, thresh_reg};
    end

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    // input word capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg           <= s_tuser;
            now_reg          <= s_tdata[31:0];
            key_time_reg     <= s_tdata[63:32];
            key_color_reg[0] <= s_tdata[71:64];
            key_color_reg[1] <= s_tdata[79:72];
            key_color_reg[2] <= s_tdata[87:80];
        end
    end

    // keyframe, speed, color and flag state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg   <= '0;
            target_time_reg <= '0;
            reached_reg     <= 1'b0;
            refresh_reg     <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                prev_color_reg[c]   <= '0;
                target_color_reg[c] <= '0;
                shown_reg[c]        <= '0;
                expected_reg[c]     <= '0;
                speed_reg[c]        <= '0;
            end
        end else begin
            if (cmd.load) begin
                prev_time_reg   <= target_time_reg;
                target_time_reg <= key_time_reg;
                reached_reg     <= 1'b0;
                for (int c = 0; c < CHANNELS; c++) begin
                    prev_color_reg[c]   <= target_color_reg[c];
                    target_color_reg[c] <= key_color_reg[c];
                end
            end
            if (cmd.div_store) begin
                if (left_reg == '0) begin
                    speed_reg[chan_reg] <= '0;
                end else if (div_neg_reg) begin
                    speed_reg[chan_reg] <= -$signed({1'b0, quo_reg});
                end else begin
                    speed_reg[chan_reg] <= $signed({1'b0, quo_reg});
                end
            end
            if (cmd.tick_reach) begin
                reached_reg <= 1'b1;
                refresh_reg <= 1'b1;
            end
            if (cmd.acc) begin
                expected_reg[chan_reg] <= sat_val;
            end
            if (cmd.tick_end) begin
                refresh_reg <= any_reg;
            end
            if (cmd.commit) begin
                refresh_reg <= 1'b0;
                for (int c = 0; c < CHANNELS; c++) begin
                    shown_reg[c] <= expected_reg[c];
                end
            end
        end
    end

    // channel counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg <= '0;
        end else if (cmd.load || cmd.tick_start) begin
            chan_reg <= '0;
        end else if (cmd.div_store || cmd.acc) begin
            chan_reg <= chan_reg + 1'b1;
        end
    end

    // time left and restoring divider
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            left_reg <= (key_time_reg > now_reg) ? (key_time_reg - now_reg) : '0;
        end
        if (cmd.div_init) begin
            rem_reg     <= '0;
            quo_reg     <= {color_mag[COLOR_BITS-1:0], {FRAC_BITS{1'b0}}};
            cnt_reg     <= '0;
            div_neg_reg <= color_diff[COLOR_BITS];
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? rem_sub[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
            quo_reg <= {quo_reg[QUO_BITS-2:0], div_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // time offset, product and refresh accumulation
    always_ff @(posedge aclk) begin
        if (cmd.tick_start) begin
            dneg_reg <= now_reg < prev_time_reg;
            dmag_reg <= (now_reg < prev_time_reg) ? (prev_time_reg - now_reg)
                                                  : (now_reg - prev_time_reg);
            any_reg  <= 1'b0;
        end else if (cmd.acc) begin
            any_reg <= any_reg | chan_any;
        end
        if (cmd.mul) begin
            prod_reg <= speed_mag[QUO_BITS-1:0] * dmag_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result) begin
            m_tdata_reg <= {6'd0, expected_reg[2], expected_reg[1], expected_reg[0],
                            reached_reg, refresh_reg};
        end
    end

    // status to controller
    always_comb begin
        stat.op            = op_reg;
        stat.reached       = reached_reg;
        stat.now_ge_target = now_reg >= target_time_reg;
        stat.div_last      = cnt_reg == DIV_LAST;
        stat.chan_last     = chan_reg == CHAN_LAST;
        stat.out_free      = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[tb/sv/tb_keyframe_rgb_fade_engine_unit.sv]
// testbench for the keyframe rgb fade engine: fade sequences, noise, threshold phases
`timescale 1ns / 1ps

module tb_keyframe_rgb_fade_engine_unit;
    import kfade_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 400;
    localparam int         PHASE_CMDS  = 310;

    // one command word as offered on the input stream
    typedef struct packed {
        logic [1:0]   opcode;
        logic [31:0]  elapsed_ms;
        logic [31:0]  key_time_ms;
        color_t [2:0] key_col;      // red at index 0
    } fade_cmd_t;

    // one report word as seen on the result stream
    typedef struct packed {
        logic         needs_update;
        logic         past_target;
        color_t [2:0] col;
    } color_report_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata = '0;
    logic [1:0]             s_tuser = OP_TICK;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [COLOR_BITS-1:0]  cfg_data = '0;

    keyframe_rgb_fade_engine_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // pending commands and the reports they must produce
    fade_cmd_t     fade_cmd_q[$];
    color_report_t color_report_q[$];
    fade_cmd_t     offered;

    // handshake pressure knobs
    int tx_idle_pct  = 20;
    int rx_stall_pct = 20;
    bit rx_hold_req  = 1'b0;
    bit rx_hold      = 1'b0;

    // fade state of the predictor
    color_t         thresh_m = THRESH_RESET;
    logic [31:0]    prev_ms = '0;
    logic [31:0]    tgt_ms = '0;
    color_t [2:0]   prev_col = '0;
    color_t [2:0]   tgt_col = '0;
    color_t [2:0]   shown_col = '0;
    color_t [2:0]   exp_col = '0;
    longint         spd_q16[CHANNELS] = '{0, 0, 0};
    bit             reached = 1'b0;
    bit             refresh = 1'b0;

    // stimulus time base and run statistics
    logic [31:0] anim_ms;
    int n_load = 0, n_tick = 0, n_commit = 0, n_unused = 0;
    int n_reach = 0, n_refresh = 0, n_checked = 0, n_mismatch = 0;
    color_t thr_c, thr_d;

    // signed q16 speed, truncated toward zero, zero when no time is left
    function automatic longint chan_speed(color_t to, color_t from, longint unsigned left);
        int              diff;
        longint unsigned mag;
        longint          q;
        diff = int'(to) - int'(from);
        if (left == 0) return 0;
        mag = (diff < 0) ? -diff : diff;
        mag = mag << FRAC_BITS;
        q = longint'(mag / left);
        return (diff < 0) ? -q : q;
    endfunction

    // base plus speed times signed time offset, floored and clamped to 0..255
    function automatic color_t color_at(color_t base, longint spd, longint unsigned dmag,
                                        bit dneg);
        longint unsigned smag;
        longint unsigned lim;
        bit              sneg;
        longint          total;
        lim = 64'd1 << SAT_SHIFT;
        if (spd == 0) return base;
        sneg = spd < 0;
        smag = sneg ? -spd : spd;
        // products beyond 1024 color units clamp by sign alone
        if (dmag > lim / smag) return (sneg != dneg) ? 8'd0 : 8'd255;
        total = longint'(base) <<< FRAC_BITS;
        if (sneg != dneg) total = total - longint'(smag * dmag);
        else              total = total + longint'(smag * dmag);
        if (total < 0) return 8'd0;
        if ((total >>> FRAC_BITS) > 255) return 8'd255;
        return color_t'(total >>> FRAC_BITS);
    endfunction

    // apply one accepted command to the fade state and return its report
    function automatic color_report_t advance_fade(fade_cmd_t cmd);
        color_report_t   rep;
        longint unsigned left;
        longint unsigned dmag;
        bit              dneg;
        bit              any;
        int              d;
        case (cmd.opcode)
            OP_LOAD: begin
                n_load++;
                left = (cmd.key_time_ms > cmd.elapsed_ms) ? cmd.key_time_ms - cmd.elapsed_ms : 0;
                prev_ms = tgt_ms;
                tgt_ms  = cmd.key_time_ms;
                for (int c = 0; c < CHANNELS; c++) begin
                    prev_col[c] = tgt_col[c];
                    tgt_col[c]  = cmd.key_col[c];
                    spd_q16[c]  = chan_speed(tgt_col[c], prev_col[c], left);
                end
                reached = 1'b0;
            end
            OP_TICK: begin
                n_tick++;
                // reaching the target only raises the flags
                if (!reached && cmd.elapsed_ms >= tgt_ms) begin
                    reached = 1'b1;
                    refresh = 1'b1;
                    n_reach++;
                end
                if (!reached) begin
                    dneg = cmd.elapsed_ms < prev_ms;
                    dmag = dneg ? prev_ms - cmd.elapsed_ms : cmd.elapsed_ms - prev_ms;
                    any  = 1'b0;
                    for (int c = 0; c < CHANNELS; c++) begin
                        exp_col[c] = color_at(prev_col[c], spd_q16[c], dmag, dneg);
                        d = int'(exp_col[c]) - int'(shown_col[c]);
                        if (d < 0) d = -d;
                        if (d > int'(thresh_m)) any = 1'b1;
                    end
                    refresh = any;
                    if (any) n_refresh++;
                end
            end
            OP_COMMIT: begin
                n_commit++;
                shown_col = exp_col;
                refresh   = 1'b0;
            end
            default: n_unused++;
        endcase
        rep.needs_update = refresh;
        rep.past_target  = reached;
        rep.col          = exp_col;
        return rep;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_mismatch++;
        end
    endfunction

    function automatic color_t pick_color();
        case ($urandom_range(3, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return color_t'($urandom);
        endcase
    endfunction

    task automatic push_cmd(logic [1:0] op, logic [31:0] now, logic [31:0] kt,
                            logic [23:0] col);
        fade_cmd_t cmd;
        cmd.opcode      = op;
        cmd.elapsed_ms  = now;
        cmd.key_time_ms = kt;
        cmd.key_col     = col;
        fade_cmd_q.push_back(cmd);
    endtask

    // mostly well-formed fades: a load, then ticks forward or back, commits, some stray words
    task automatic queue_fade_phase(int n_cmds);
        int          n_left;
        int          span;
        int          roll;
        logic [31:0] kt;
        n_left = n_cmds;
        while (n_left > 0) begin
            if ($urandom_range(99, 0) < 15) begin
                push_cmd(2'($urandom), $urandom, $urandom, 24'($urandom));
                n_left--;
            end else begin
                if ($urandom_range(9, 0) == 0) anim_ms = $urandom;
                span = ($urandom_range(3, 0) == 0) ? $urandom_range(60000, 1)
                                                   : $urandom_range(2000, 1);
                kt = anim_ms + 32'(span);
                // keyframe already due: no time left
                if ($urandom_range(15, 0) == 0) kt = anim_ms - 32'($urandom_range(100, 0));
                push_cmd(OP_LOAD, anim_ms, kt, {pick_color(), pick_color(), pick_color()});
                n_left--;
                repeat ($urandom_range(10, 2)) begin
                    if (n_left > 0) begin
                        roll = $urandom_range(99, 0);
                        if (roll < 70) begin
                            anim_ms = anim_ms + 32'($urandom_range(span / 3 + 1, 0));
                            push_cmd(OP_TICK, anim_ms, $urandom, 24'($urandom));
                        end else if (roll < 80) begin
                            // time stepped back behind the current animation time
                            push_cmd(OP_TICK, anim_ms - 32'($urandom_range(5000, 1)),
                                     $urandom, 24'($urandom));
                        end else if (roll < 95) begin
                            push_cmd(OP_COMMIT, anim_ms, $urandom, 24'($urandom));
                        end else begin
                            push_cmd(OP_UNUSED, anim_ms, $urandom, 24'($urandom));
                        end
                        n_left--;
                    end
                end
            end
        end
    endtask

    task automatic drain_fade();
        do @(negedge aclk);
        while (fade_cmd_q.size() != 0 || s_tvalid || color_report_q.size() != 0);
    endtask

    // wait for idle, write the threshold, then set the handshake pressure
    task automatic start_phase(color_t thr, int tx_pct, int rx_pct);
        drain_fade();
        repeat (8) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= thr;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        thresh_m = thr;
        @(negedge aclk);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                color_report_q.push_back(advance_fade(offered));
            end
            if (!s_tvalid || s_tready) begin
                if (fade_cmd_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                    offered = fade_cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered.key_col, offered.key_time_ms, offered.elapsed_ms};
                    s_tuser  <= offered.opcode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin : report_check
        color_report_t got;
        color_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.needs_update = m_tdata[0];
                got.past_target  = m_tdata[1];
                got.col[0]       = m_tdata[9:2];
                got.col[1]       = m_tdata[17:10];
                got.col[2]       = m_tdata[25:18];
                if (color_report_q.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    n_mismatch++;
                end else begin
                    want = color_report_q.pop_front();
                    check_field("needs_update", want.needs_update, got.needs_update);
                    check_field("past_target", want.past_target, got.past_target);
                    check_field("out_red", want.col[0], got.col[0]);
                    check_field("out_green", want.col[1], got.col[1]);
                    check_field("out_blue", want.col[2], got.col[2]);
                    n_checked++;
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // long receiver hold so the block backs up into its input
    initial begin
        wait (rx_hold_req);
        @(negedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        rx_hold = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("tb_keyframe_rgb_fade_engine_unit failed");
        $finish;
    end

    initial begin
        anim_ms = 32'($urandom_range(100000, 0));
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset threshold, corner times and colors
        push_cmd(OP_TICK, 32'd0, '1, '1);                    // target reached straight from reset
        push_cmd(OP_UNUSED, '1, '1, '1);
        push_cmd(OP_COMMIT, 32'd0, 32'd0, 24'd0);
        push_cmd(OP_LOAD, 32'd0, 32'd1000, 24'h80_00_FF);
        push_cmd(OP_TICK, 32'd0, 32'd0, 24'd0);
        push_cmd(OP_TICK, 32'd500, '1, '1);
        push_cmd(OP_COMMIT, 32'd500, 32'd0, 24'd0);
        push_cmd(OP_TICK, 32'd999, 32'd0, 24'd0);
        push_cmd(OP_TICK, 32'd1000, 32'd0, 24'd0);          // exactly at target
        push_cmd(OP_TICK, 32'd1200, 32'd0, 24'd0);          // already past, no change
        push_cmd(OP_LOAD, 32'd1000, 32'd1001, 24'h00_FF_00); // full swing in one ms
        push_cmd(OP_TICK, 32'd0, 32'd0, 24'd0);             // before previous key, clamps
        push_cmd(OP_TICK, 32'd1000, 32'd0, 24'd0);
        push_cmd(OP_COMMIT, 32'd1000, 32'd0, 24'd0);
        push_cmd(OP_TICK, 32'hFFFF_FFFF, 32'd0, 24'd0);
        push_cmd(OP_LOAD, 32'd10, 32'd5, 24'hFF_FF_FF);      // key already due, zero speed
        push_cmd(OP_TICK, 32'd3, 32'd0, 24'd0);
        push_cmd(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd0);
        push_cmd(OP_TICK, 32'hFFFF_FFFE, 32'd0, 24'd0);
        push_cmd(OP_LOAD, 32'd0, 32'h0001_0000, 24'hFF_80_01);
        push_cmd(OP_TICK, 32'h8000_0000, 32'd0, 24'd0);
        push_cmd(OP_TICK, 32'h0000_8000, 32'd0, 24'd0);
        push_cmd(OP_COMMIT, 32'd0, '1, '1);
        push_cmd(OP_UNUSED, 32'd0, 32'd0, 24'd0);

        // no idling, lowest threshold, one long receiver hold
        start_phase(8'd0, 0, 0);
        rx_hold_req = 1'b1;
        queue_fade_phase(PHASE_CMDS);

        // sparse sender, highest threshold
        start_phase(8'd255, 80, 0);
        queue_fade_phase(PHASE_CMDS);

        // slow receiver
        thr_c = color_t'($urandom_range(64, 1));
        start_phase(thr_c, 0, 80);
        queue_fade_phase(PHASE_CMDS);

        // both sides idle
        thr_d = color_t'($urandom);
        start_phase(thr_d, 37, 37);
        queue_fade_phase(PHASE_CMDS);

        drain_fade();
        repeat (100) @(posedge aclk);

        $display("checked %0d words: %0d loads, %0d ticks, %0d commits, %0d unused opcodes",
                 n_checked, n_load, n_tick, n_commit, n_unused);
        $display("target reached %0d times, refresh raised %0d times; thresholds 0 255 %0d %0d",
                 n_reach, n_refresh, thr_c, thr_d);
        if (n_mismatch == 0) begin
            $display("tb_keyframe_rgb_fade_engine_unit passed");
        end else begin
            $display("tb_keyframe_rgb_fade_engine_unit failed");
        end
        $finish;
    end

endmodule
